FILE: rtl/rational_reduce_bounded_defines.svh
// Assertion macros used by the checker file of rational_reduce_bounded.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef RATIONAL_REDUCE_BOUNDED_DEFINES_SVH
`define RATIONAL_REDUCE_BOUNDED_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define RRB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define RRB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rrb_pkg.sv
// Package for rational_reduce_bounded: port widths, parameter defaults
// and the sequencer state type. No dependencies.
package rrb_pkg;

  // Fixed widths of the limit and result ports.
  localparam int LIM_W = 31;
  localparam int NUM_W = 32;
  localparam int DEN_W = 31;

  // Defaults for the top-level parameters.
  localparam int IN_WIDTH_DEF  = 64;
  localparam int OUT_WIDTH_DEF = 32;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_GCD,
    S_GCD_STEP,
    S_RED_N,
    S_RED_D,
    S_FIT,
    S_CF,
    S_CF_MN,
    S_CF_MD,
    S_CF_UPD,
    S_DONE
  } state_t;

endpackage

FILE: rtl/rational_reduce_bounded.sv
// Top level of rational_reduce_bounded: bounded rational approximation by
// Euclid's gcd and continued-fraction convergents. Depends on rrb_pkg.
//
//   channel  | handshake        | beat contents
//   ---------+------------------+-------------------------------------------
//   command  | start, busy      | numerator, denominator, limit
//   result   | done (strobe)    | out_num, out_den, exact
//
// Every division (gcd steps, the two reducing divisions and the partial
// quotients) runs on one shared restoring divider; a shared multiplier
// and adder form each convergent. An item runs the gcd steps and the two
// reducing divisions, then, unless the reduced terms fit, one convergent
// per partial quotient until a term would exceed the limit or the expansion ends.
// Reset (rst, synchronous) returns the sequencer to idle; busy is high
// from the cycle after a command beat until the done strobe. Results are
// shown for one cycle and cannot be held off by the receiver.
module rational_reduce_bounded #(
  parameter int IN_WIDTH  = rrb_pkg::IN_WIDTH_DEF,
  parameter int OUT_WIDTH = rrb_pkg::OUT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [IN_WIDTH-1:0]        numerator,
  input  logic signed [IN_WIDTH-1:0]        denominator,
  input  logic        [rrb_pkg::LIM_W-1:0]  limit,
  output logic                              done,
  output logic signed [rrb_pkg::NUM_W-1:0]  out_num,
  output logic        [rrb_pkg::DEN_W-1:0]  out_den,
  output logic                              exact
);

  // Term width, common compare width and divider counter width.
  localparam int PW    = OUT_WIDTH - 1;
  localparam int CW    = (IN_WIDTH > PW) ? IN_WIDTH : PW;
  localparam int SW    = 2 * PW + 1;
  localparam int CNT_W = $clog2(IN_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(IN_WIDTH - 1);
  localparam logic [rrb_pkg::LIM_W-1:0] CAP = rrb_pkg::LIM_W'((64'd1 << PW) - 64'd1);

  rrb_pkg::state_t st, st_next, ret_st, ret_st_next;

  logic [IN_WIDTH-1:0] div_quo, div_quo_next;
  logic [IN_WIDTH-1:0] div_rem, div_rem_next;
  logic [IN_WIDTH-1:0] div_b, div_b_next;
  logic [CNT_W-1:0]    cnt, cnt_next;

  logic [IN_WIDTH-1:0] ga, ga_next, gb, gb_next;
  logic [IN_WIDTH-1:0] n, n_next, d, d_next;
  logic [PW-1:0]       lim, lim_next;
  logic                neg, neg_next;
  logic [PW-1:0]       p0n, p0n_next, p0d, p0d_next;
  logic [PW-1:0]       p1n, p1n_next, p1d, p1d_next;
  logic [PW-1:0]       nn, nn_next;
  logic                ovn, ovn_next;
  logic [2*PW-1:0]     prod, prod_next;

  // Divider datapath: one quotient bit per cycle.
  logic [IN_WIDTH:0]   rem_sh;
  logic [IN_WIDTH:0]   diff;

  // Magnitudes of the command fields.
  logic [IN_WIDTH-1:0] n_mag, d_mag;

  // Compare, multiply and add helpers for the convergent step.
  logic [CW-1:0]       n_cw, d_cw, lim_cw, q_cw;
  logic [PW-1:0]       q_low;
  logic                q_hi_nz;
  logic [PW-1:0]       mul_b, add_c;
  logic [SW-1:0]       sum;
  logic                term_over;
  logic [rrb_pkg::NUM_W-1:0] num_ext;

  always_comb begin
    rem_sh = {div_rem, div_quo[IN_WIDTH-1]};
    diff   = rem_sh - {1'b0, div_b};
    n_mag  = numerator[IN_WIDTH-1] ? (~numerator + 1'b1) : numerator;
    d_mag  = denominator[IN_WIDTH-1] ? (~denominator + 1'b1) : denominator;
    n_cw   = CW'(n);
    d_cw   = CW'(d);
    lim_cw = CW'(lim);
    q_cw   = CW'(div_quo);
    q_low  = q_cw[PW-1:0];
    q_hi_nz = (q_cw >> PW) != '0;
  end

  // Shared multiplier and adder: numerator term first, then denominator.
  always_comb begin
    mul_b = (st == rrb_pkg::S_CF_MN) ? p1n : p1d;
    add_c = (st == rrb_pkg::S_CF_MD) ? p0n : p0d;
    sum   = SW'(prod) + SW'(add_c);
    // The term is too large if the added term exceeds the limit, the product
    // is known to overflow the cap, or the full-width sum exceeds the limit.
    term_over = (add_c > lim) ||
                (q_hi_nz && (((st == rrb_pkg::S_CF_MD) ? p1n : p1d) != '0)) ||
                (sum > SW'(lim));
  end

  // Sequencer: next state and all register updates.
  always_comb begin
    st_next      = st;
    ret_st_next  = ret_st;
    div_quo_next = div_quo;
    div_rem_next = div_rem;
    div_b_next   = div_b;
    cnt_next     = cnt;
    ga_next      = ga;
    gb_next      = gb;
    n_next       = n;
    d_next       = d;
    lim_next     = lim;
    neg_next     = neg;
    p0n_next     = p0n;
    p0d_next     = p0d;
    p1n_next     = p1n;
    p1d_next     = p1d;
    nn_next      = nn;
    ovn_next     = ovn;
    prod_next    = prod;

    case (st)
      rrb_pkg::S_IDLE: begin
        if (start) begin
          n_next   = n_mag;
          d_next   = d_mag;
          ga_next  = n_mag;
          gb_next  = d_mag;
          neg_next = numerator[IN_WIDTH-1] ^ denominator[IN_WIDTH-1];
          lim_next = (limit > CAP) ? CAP[PW-1:0] : limit[PW-1:0];
          st_next  = rrb_pkg::S_GCD;
        end
      end

      // One restoring division step per cycle.
      rrb_pkg::S_DIV: begin
        if (!diff[IN_WIDTH]) begin
          div_rem_next = diff[IN_WIDTH-1:0];
          div_quo_next = {div_quo[IN_WIDTH-2:0], 1'b1};
        end else begin
          div_rem_next = rem_sh[IN_WIDTH-1:0];
          div_quo_next = {div_quo[IN_WIDTH-2:0], 1'b0};
        end
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          st_next = ret_st;
        end
      end

      // Euclid: a, b <- b, a mod b until b is zero.
      rrb_pkg::S_GCD: begin
        if (gb != '0) begin
          div_quo_next = ga;
          div_b_next   = gb;
          div_rem_next = '0;
          cnt_next     = '0;
          ret_st_next  = rrb_pkg::S_GCD_STEP;
          st_next      = rrb_pkg::S_DIV;
        end else if (ga == '0) begin
          st_next = rrb_pkg::S_FIT;
        end else begin
          div_quo_next = n;
          div_b_next   = ga;
          div_rem_next = '0;
          cnt_next     = '0;
          ret_st_next  = rrb_pkg::S_RED_N;
          st_next      = rrb_pkg::S_DIV;
        end
      end

      rrb_pkg::S_GCD_STEP: begin
        ga_next = gb;
        gb_next = div_rem;
        st_next = rrb_pkg::S_GCD;
      end

      // Divide both magnitudes by the gcd.
      rrb_pkg::S_RED_N: begin
        n_next       = div_quo;
        div_quo_next = d;
        div_b_next   = ga;
        div_rem_next = '0;
        cnt_next     = '0;
        ret_st_next  = rrb_pkg::S_RED_D;
        st_next      = rrb_pkg::S_DIV;
      end

      rrb_pkg::S_RED_D: begin
        d_next  = div_quo;
        st_next = rrb_pkg::S_FIT;
      end

      // Exact when both reduced terms fit; else start from 0/1 and 1/0.
      rrb_pkg::S_FIT: begin
        p0n_next = '0;
        p0d_next = PW'(1);
        if ((n_cw <= lim_cw) && (d_cw <= lim_cw)) begin
          p1n_next = n_cw[PW-1:0];
          p1d_next = d_cw[PW-1:0];
          d_next   = '0;
          st_next  = rrb_pkg::S_DONE;
        end else begin
          p1n_next = PW'(1);
          p1d_next = '0;
          st_next  = rrb_pkg::S_CF;
        end
      end

      // Next partial quotient, unless the expansion has ended.
      rrb_pkg::S_CF: begin
        if (d == '0) begin
          st_next = rrb_pkg::S_DONE;
        end else begin
          div_quo_next = n;
          div_b_next   = d;
          div_rem_next = '0;
          cnt_next     = '0;
          ret_st_next  = rrb_pkg::S_CF_MN;
          st_next      = rrb_pkg::S_DIV;
        end
      end

      rrb_pkg::S_CF_MN: begin
        prod_next = (2 * PW)'(q_low) * (2 * PW)'(mul_b);
        st_next   = rrb_pkg::S_CF_MD;
      end

      rrb_pkg::S_CF_MD: begin
        nn_next   = sum[PW-1:0];
        ovn_next  = term_over;
        prod_next = (2 * PW)'(q_low) * (2 * PW)'(mul_b);
        st_next   = rrb_pkg::S_CF_UPD;
      end

      // Accept the new convergent, or stop before it.
      rrb_pkg::S_CF_UPD: begin
        if (ovn || term_over) begin
          st_next = rrb_pkg::S_DONE;
        end else begin
          p0n_next = p1n;
          p0d_next = p1d;
          p1n_next = nn;
          p1d_next = sum[PW-1:0];
          n_next   = d;
          d_next   = div_rem;
          st_next  = rrb_pkg::S_CF;
        end
      end

      rrb_pkg::S_DONE: begin
        st_next = rrb_pkg::S_IDLE;
      end

      default: begin
        st_next = rrb_pkg::S_IDLE;
      end
    endcase
  end

  // State register; only the sequencer state is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= rrb_pkg::S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ret_st  <= ret_st_next;
    div_quo <= div_quo_next;
    div_rem <= div_rem_next;
    div_b   <= div_b_next;
    cnt     <= cnt_next;
    ga      <= ga_next;
    gb      <= gb_next;
    n       <= n_next;
    d       <= d_next;
    lim     <= lim_next;
    neg     <= neg_next;
    p0n     <= p0n_next;
    p0d     <= p0d_next;
    p1n     <= p1n_next;
    p1d     <= p1d_next;
    nn      <= nn_next;
    ovn     <= ovn_next;
    prod    <= prod_next;
  end

  // Result beat: sign from the XOR of the input signs.
  always_comb begin
    busy    = (st != rrb_pkg::S_IDLE);
    done    = (st == rrb_pkg::S_DONE);
    num_ext = rrb_pkg::NUM_W'(p1n);
    out_num = neg ? (~num_ext + 1'b1) : num_ext;
    out_den = rrb_pkg::DEN_W'(p1d);
    exact   = (d == '0);
  end

endmodule

FILE: rtl/rrb_checker.sv
// Port-level checker for rational_reduce_bounded, bound to the top level.
// Depends on rational_reduce_bounded_defines.svh for the assertion macros.
`include "rational_reduce_bounded_defines.svh"

module rrb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A command beat makes the block busy in the next cycle.
  `RRB_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy missing after command beat")

  // A result beat appears only while an item is in work.
  `RRB_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "result beat while idle")

  // Each item gives one result beat, one cycle long.
  `RRB_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy, "result beat longer than one cycle")

  // An idle block cannot finish in the next cycle.
  `RRB_ASSERT_NEXT(a_no_instant, clk, rst, !busy, !done, "result beat right after idle")

endmodule

bind rational_reduce_bounded rrb_checker u_rrb_checker (.*);
